FILE: rtl/chol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky 3x3 package
// Word types, the data width and the status codes shared by the block.
// ----------------------------------------------------------------------------
package chol_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int DIAG_WIDTH = DATA_WIDTH - 1;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK  = 2'd0;
   localparam status_type STATUS_NPD = 2'd1;
   localparam status_type STATUS_SAT = 2'd2;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] cov_00;
      logic signed [DATA_WIDTH-1:0] cov_10;
      logic signed [DATA_WIDTH-1:0] cov_11;
      logic signed [DATA_WIDTH-1:0] cov_20;
      logic signed [DATA_WIDTH-1:0] cov_21;
      logic signed [DATA_WIDTH-1:0] cov_22;
   } req_type;

   typedef struct packed {
      logic        [DIAG_WIDTH-1:0] fac_00;
      logic signed [DATA_WIDTH-1:0] fac_10;
      logic        [DIAG_WIDTH-1:0] fac_11;
      logic signed [DATA_WIDTH-1:0] fac_20;
      logic signed [DATA_WIDTH-1:0] fac_21;
      logic        [DIAG_WIDTH-1:0] fac_22;
      status_type                   status;
   } rsp_type;

endpackage

FILE: rtl/chol_fxmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Registered signed product, shifted right by the fraction bits (floor).
// ----------------------------------------------------------------------------
module chol_fxmul #(
   parameter int WIDTH     = 32,
   parameter int FRAC_BITS = 16,
   parameter int PROD_W    = 2 * WIDTH - FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [WIDTH-1:0]  in_a,
   input  logic signed [WIDTH-1:0]  in_b,
   output logic signed [PROD_W-1:0] out_prod
);

   localparam int PW = 2 * WIDTH;

   logic signed [PW-1:0]     prod;
   logic signed [PROD_W-1:0] prod_ff;

   assign prod = PW'(in_a) * PW'(in_b);

   // An arithmetic shift rounds towards minus infinity.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PROD_W'(prod >>> FRAC_BITS);
      end
   end

   assign out_prod = prod_ff;

endmodule

FILE: rtl/chol_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined square root
// floor(sqrt(r << FRAC_BITS)), one root bit per register stage.
// ----------------------------------------------------------------------------
module chol_sqrt #(
   parameter int RAD_W     = 31,
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 1,
   parameter int ROOT_W    = (RAD_W + FRAC_BITS + 1) / 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int XW  = 2 * ROOT_W;
   localparam int RMW = ROOT_W + 3;

   logic              valid_ff [ROOT_W];
   logic [XW-1:0]     x_ff     [ROOT_W];
   logic [RMW-1:0]    rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];
   logic [XW-1:0]     x_first;

   assign x_first = XW'({in_rad, {FRAC_BITS{1'b0}}});

   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      logic              vld_prev;
      logic [XW-1:0]     x_prev;
      logic [RMW-1:0]    rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [RMW-1:0]    rem_cat;
      logic [RMW-1:0]    trial;
      logic [RMW-1:0]    rem_in;
      logic [ROOT_W-1:0] root_in;

      if (i == 0) begin : g_head
         assign vld_prev  = in_valid;
         assign x_prev    = x_first;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_body
         assign vld_prev  = valid_ff[i-1];
         assign x_prev    = x_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      // Bring down the next two radicand bits and try the next root bit.
      always_comb begin
         rem_cat = {rem_prev[RMW-3:0], x_prev[XW-1 -: 2]};
         trial   = RMW'({root_prev, 2'b01});
         if (rem_cat >= trial) begin
            rem_in  = rem_cat - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_cat;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= vld_prev;
         end
         if (en) begin
            x_ff[i]    <= x_prev << 2;
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

FILE: rtl/chol_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined saturating divider
// (num << FRAC_BITS) / den towards zero, saturated to OUT_W signed bits.
// ----------------------------------------------------------------------------
module chol_div #(
   parameter int NUM_W     = 32,
   parameter int DEN_W     = 24,
   parameter int OUT_W     = 32,
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0]        in_den,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic signed [OUT_W-1:0] out_quo,
   output logic                    out_sat,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int DVW = NUM_W + FRAC_BITS;
   localparam int EXW = DVW + DEN_W;
   localparam int CW  = DVW + DEN_W + OUT_W;
   localparam logic [OUT_W-1:0] MAX_POS = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] MIN_NEG = {1'b1, {(OUT_W-1){1'b0}}};

   logic              valid_ff [OUT_W+1];
   logic [DEN_W-1:0]  rem_ff   [OUT_W+1];
   logic [OUT_W-1:0]  low_ff   [OUT_W+1];
   logic [OUT_W-1:0]  quo_ff   [OUT_W+1];
   logic [DEN_W-1:0]  den_ff   [OUT_W+1];
   logic              neg_ff   [OUT_W+1];
   logic              sat_ff   [OUT_W+1];
   logic [SIDE_W-1:0] side_ff  [OUT_W+1];

   logic [NUM_W-1:0] num_u;
   logic [NUM_W-1:0] mag;
   logic             neg;
   logic [DVW-1:0]   dvd;
   logic [EXW-1:0]   dext;
   logic [CW-1:0]    lim_d;
   logic [CW-1:0]    thr;
   logic             sat_first;

   // Saturation is decided up front against den * 2^(OUT_W-1), so only
   // OUT_W quotient bits need to be developed.
   always_comb begin
      num_u     = in_num;
      neg       = in_num[NUM_W-1];
      mag       = neg ? (~num_u + NUM_W'(1)) : num_u;
      dvd       = {mag, {FRAC_BITS{1'b0}}};
      dext      = EXW'(dvd);
      lim_d     = CW'(in_den) << (OUT_W - 1);
      thr       = neg ? (lim_d + CW'(in_den)) : lim_d;
      sat_first = (CW'(dvd) >= thr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= dext[OUT_W +: DEN_W];
         low_ff[0]  <= dvd[OUT_W-1:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         neg_ff[0]  <= neg;
         sat_ff[0]  <= sat_first;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= OUT_W; k++) begin : g_bit
      logic [DEN_W:0]   rem_cat;
      logic [DEN_W:0]   den_ext;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      always_comb begin
         rem_cat = {rem_ff[k-1], low_ff[k-1][OUT_W-1]};
         den_ext = {1'b0, den_ff[k-1]};
         ge      = (rem_cat >= den_ext);
         rem_in  = ge ? DEN_W'(rem_cat - den_ext) : rem_cat[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            low_ff[k]  <= low_ff[k-1] << 1;
            quo_ff[k]  <= {quo_ff[k-1][OUT_W-2:0], ge};
            den_ff[k]  <= den_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   logic              out_valid_ff;
   logic [OUT_W-1:0]  quo_out_ff;
   logic [OUT_W-1:0]  quo_out_in;
   logic              sat_out_ff;
   logic [SIDE_W-1:0] side_out_ff;

   always_comb begin
      if (sat_ff[OUT_W]) begin
         quo_out_in = neg_ff[OUT_W] ? MIN_NEG : MAX_POS;
      end else begin
         quo_out_in = neg_ff[OUT_W] ? (~quo_ff[OUT_W] + OUT_W'(1)) : quo_ff[OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[OUT_W];
      end
      if (en) begin
         quo_out_ff  <= quo_out_in;
         sat_out_ff  <= sat_ff[OUT_W];
         side_out_ff <= side_ff[OUT_W];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quo   = quo_out_ff;
   assign out_sat   = sat_out_ff;
   assign out_side  = side_out_ff;

endmodule

FILE: rtl/cholesky_3x3_decomposition_unit.sv
`timescale 1ns / 1ps
// Each square root develops R = (D + FRAC_BITS) / 2 root bits, D = data width (Q16.16).
// Throughput: one word per cycle unless a result word waits on the output, set by
// the bit-per-stage square root and divider pipelines; the whole pipeline then holds.
// Reset clears the valid bits of every stage.
// ----------------------------------------------------------------------------
// Cholesky 3x3 decomposition unit
// Three pipelined square roots and three dividers give the lower factor.
// ----------------------------------------------------------------------------
module cholesky_3x3_decomposition_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  chol_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output chol_pkg::rsp_type rsp_data
);

   localparam int W    = chol_pkg::DATA_WIDTH;
   localparam int DG   = chol_pkg::DIAG_WIDTH;
   localparam int RW   = (W - 1 + FRAC_BITS + 1) / 2;
   localparam int MW   = 2 * W - FRAC_BITS;
   localparam int MXW  = (MW > W) ? MW : W;
   localparam int N21W = MXW + 1;
   localparam int R1W  = MXW + 1;
   localparam int R2W  = ((MW + 1 > W) ? MW + 1 : W) + 1;

   typedef struct packed {
      logic              npd;
      logic signed [W-1:0] a10;
      logic signed [W-1:0] a11;
      logic signed [W-1:0] a20;
      logic signed [W-1:0] a21;
      logic signed [W-1:0] a22;
   } side_a_type;

   typedef struct packed {
      logic              npd;
      logic [RW-1:0]     l00;
      logic signed [W-1:0] a11;
      logic signed [W-1:0] a22;
   } side_b_type;

   typedef struct packed {
      logic              npd;
      logic              sat;
      logic [RW-1:0]     l00;
      logic signed [W-1:0] l10;
      logic signed [W-1:0] l20;
      logic signed [W-1:0] a11;
      logic signed [W-1:0] a21;
      logic signed [W-1:0] a22;
   } stage_c_type;

   typedef struct packed {
      logic                 npd;
      logic                 sat;
      logic [RW-1:0]        l00;
      logic signed [W-1:0]  l10;
      logic signed [W-1:0]  l20;
      logic signed [W-1:0]  a22;
      logic signed [N21W-1:0] n21;
   } side_e_type;

   typedef struct packed {
      logic              npd;
      logic              sat;
      logic [RW-1:0]     l00;
      logic signed [W-1:0] l10;
      logic signed [W-1:0] l20;
      logic [RW-1:0]     l11;
      logic signed [W-1:0] a22;
   } side_f_type;

   typedef struct packed {
      logic              npd;
      logic              sat;
      logic [RW-1:0]     l00;
      logic signed [W-1:0] l10;
      logic signed [W-1:0] l20;
      logic [RW-1:0]     l11;
      logic signed [W-1:0] l21;
      logic signed [W-1:0] a22;
   } stage_g_type;

   typedef struct packed {
      logic              npd;
      logic              sat;
      logic [RW-1:0]     l00;
      logic signed [W-1:0] l10;
      logic signed [W-1:0] l20;
      logic [RW-1:0]     l11;
      logic signed [W-1:0] l21;
   } side_i_type;

   logic adv;

   // The pipeline moves whenever the output register is free or being read.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // First square root: l00.
   side_a_type side_a_in;
   side_a_type side_a_out;
   logic       va;
   logic [RW-1:0] l00_a;

   always_comb begin
      side_a_in.npd = req_data.cov_00[W-1] || (req_data.cov_00 == '0);
      side_a_in.a10 = req_data.cov_10;
      side_a_in.a11 = req_data.cov_11;
      side_a_in.a20 = req_data.cov_20;
      side_a_in.a21 = req_data.cov_21;
      side_a_in.a22 = req_data.cov_22;
   end

   chol_sqrt #(
      .RAD_W     (W - 1),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(side_a_type))
   ) u_sqrt_00 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .in_rad    (req_data.cov_00[W-2:0]),
      .in_side   (side_a_in),
      .out_valid (va),
      .out_root  (l00_a),
      .out_side  (side_a_out)
   );

   // Column zero divisions: l10 and l20.
   side_b_type side_b_in;
   side_b_type side_b_out;
   logic       vb10;
   logic       vb20;
   logic signed [W-1:0] l10_b;
   logic signed [W-1:0] l20_b;
   logic       sat10_b;
   logic       sat20_b;
   logic [W-1:0] a21_b;

   always_comb begin
      side_b_in.npd = side_a_out.npd;
      side_b_in.l00 = l00_a;
      side_b_in.a11 = side_a_out.a11;
      side_b_in.a22 = side_a_out.a22;
   end

   chol_div #(
      .NUM_W     (W),
      .DEN_W     (RW),
      .OUT_W     (W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(side_b_type))
   ) u_div_10 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (va),
      .in_num    (side_a_out.a10),
      .in_den    (l00_a),
      .in_side   (side_b_in),
      .out_valid (vb10),
      .out_quo   (l10_b),
      .out_sat   (sat10_b),
      .out_side  (side_b_out)
   );

   chol_div #(
      .NUM_W     (W),
      .DEN_W     (RW),
      .OUT_W     (W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (W)
   ) u_div_20 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (va),
      .in_num    (side_a_out.a20),
      .in_den    (l00_a),
      .in_side   (side_a_out.a21),
      .out_valid (vb20),
      .out_quo   (l20_b),
      .out_sat   (sat20_b),
      .out_side  (a21_b)
   );

   // Products l10^2 and l20*l10.
   logic        vc_ff;
   stage_c_type c_ff;
   logic signed [MW-1:0] m11_c;
   logic signed [MW-1:0] m21_c;

   chol_fxmul #(.WIDTH(W), .FRAC_BITS(FRAC_BITS), .PROD_W(MW)) u_mul_11 (
      .clock    (clock),
      .en       (adv),
      .in_a     (l10_b),
      .in_b     (l10_b),
      .out_prod (m11_c)
   );

   chol_fxmul #(.WIDTH(W), .FRAC_BITS(FRAC_BITS), .PROD_W(MW)) u_mul_21 (
      .clock    (clock),
      .en       (adv),
      .in_a     (l20_b),
      .in_b     (l10_b),
      .out_prod (m21_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vb10 && vb20;
      end
      if (adv) begin
         c_ff.npd <= side_b_out.npd;
         c_ff.sat <= sat10_b || sat20_b;
         c_ff.l00 <= side_b_out.l00;
         c_ff.l10 <= l10_b;
         c_ff.l20 <= l20_b;
         c_ff.a11 <= side_b_out.a11;
         c_ff.a21 <= a21_b;
         c_ff.a22 <= side_b_out.a22;
      end
   end

   // Second radicand and the numerator of l21.
   logic signed [R1W-1:0] rad11;
   logic                  vd_ff;
   side_e_type            d_ff;
   side_e_type            d_in;
   logic [W-2:0]          rad11_ff;

   always_comb begin
      rad11    = R1W'(c_ff.a11) - R1W'(m11_c);
      d_in.npd = c_ff.npd || rad11[R1W-1] || (rad11 == '0);
      d_in.sat = c_ff.sat;
      d_in.l00 = c_ff.l00;
      d_in.l10 = c_ff.l10;
      d_in.l20 = c_ff.l20;
      d_in.a22 = c_ff.a22;
      d_in.n21 = N21W'(c_ff.a21) - N21W'(m21_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (adv) begin
         vd_ff <= vc_ff;
      end
      if (adv) begin
         d_ff     <= d_in;
         rad11_ff <= rad11[W-2:0];
      end
   end

   // Second square root: l11.
   side_e_type    side_e_out;
   logic          ve;
   logic [RW-1:0] l11_e;

   chol_sqrt #(
      .RAD_W     (W - 1),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(side_e_type))
   ) u_sqrt_11 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (vd_ff),
      .in_rad    (rad11_ff),
      .in_side   (d_ff),
      .out_valid (ve),
      .out_root  (l11_e),
      .out_side  (side_e_out)
   );

   // Division for l21.
   side_f_type side_f_in;
   side_f_type side_f_out;
   logic       vf;
   logic signed [W-1:0] l21_f;
   logic       sat21_f;

   always_comb begin
      side_f_in.npd = side_e_out.npd;
      side_f_in.sat = side_e_out.sat;
      side_f_in.l00 = side_e_out.l00;
      side_f_in.l10 = side_e_out.l10;
      side_f_in.l20 = side_e_out.l20;
      side_f_in.l11 = l11_e;
      side_f_in.a22 = side_e_out.a22;
   end

   chol_div #(
      .NUM_W     (N21W),
      .DEN_W     (RW),
      .OUT_W     (W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(side_f_type))
   ) u_div_21 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (ve),
      .in_num    (side_e_out.n21),
      .in_den    (l11_e),
      .in_side   (side_f_in),
      .out_valid (vf),
      .out_quo   (l21_f),
      .out_sat   (sat21_f),
      .out_side  (side_f_out)
   );

   // Squares l20^2 and l21^2.
   logic        vg_ff;
   stage_g_type g_ff;
   logic signed [MW-1:0] s20_g;
   logic signed [MW-1:0] s21_g;

   chol_fxmul #(.WIDTH(W), .FRAC_BITS(FRAC_BITS), .PROD_W(MW)) u_mul_20 (
      .clock    (clock),
      .en       (adv),
      .in_a     (side_f_out.l20),
      .in_b     (side_f_out.l20),
      .out_prod (s20_g)
   );

   chol_fxmul #(.WIDTH(W), .FRAC_BITS(FRAC_BITS), .PROD_W(MW)) u_mul_22 (
      .clock    (clock),
      .en       (adv),
      .in_a     (l21_f),
      .in_b     (l21_f),
      .out_prod (s21_g)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vg_ff <= 1'b0;
      end else if (adv) begin
         vg_ff <= vf;
      end
      if (adv) begin
         g_ff.npd <= side_f_out.npd;
         g_ff.sat <= side_f_out.sat || sat21_f;
         g_ff.l00 <= side_f_out.l00;
         g_ff.l10 <= side_f_out.l10;
         g_ff.l20 <= side_f_out.l20;
         g_ff.l11 <= side_f_out.l11;
         g_ff.l21 <= l21_f;
         g_ff.a22 <= side_f_out.a22;
      end
   end

   // Third radicand.
   logic signed [R2W-1:0] rad22;
   logic                  vh_ff;
   side_i_type            h_ff;
   side_i_type            h_in;
   logic [W-2:0]          rad22_ff;

   always_comb begin
      rad22    = R2W'(g_ff.a22) - R2W'(s20_g) - R2W'(s21_g);
      h_in.npd = g_ff.npd || rad22[R2W-1] || (rad22 == '0);
      h_in.sat = g_ff.sat;
      h_in.l00 = g_ff.l00;
      h_in.l10 = g_ff.l10;
      h_in.l20 = g_ff.l20;
      h_in.l11 = g_ff.l11;
      h_in.l21 = g_ff.l21;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vh_ff <= 1'b0;
      end else if (adv) begin
         vh_ff <= vg_ff;
      end
      if (adv) begin
         h_ff     <= h_in;
         rad22_ff <= rad22[W-2:0];
      end
   end

   // Third square root: l22.
   side_i_type    side_i_out;
   logic          vi;
   logic [RW-1:0] l22_i;

   chol_sqrt #(
      .RAD_W     (W - 1),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(side_i_type))
   ) u_sqrt_22 (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (vh_ff),
      .in_rad    (rad22_ff),
      .in_side   (h_ff),
      .out_valid (vi),
      .out_root  (l22_i),
      .out_side  (side_i_out)
   );

   // Output register. A non positive definite matrix gives an all-zero factor.
   logic              rsp_valid_ff;
   chol_pkg::rsp_type rsp_data_ff;
   chol_pkg::rsp_type rsp_data_in;

   always_comb begin
      if (side_i_out.npd) begin
         rsp_data_in        = '0;
         rsp_data_in.status = chol_pkg::STATUS_NPD;
      end else begin
         rsp_data_in.fac_00 = DG'(side_i_out.l00);
         rsp_data_in.fac_10 = side_i_out.l10;
         rsp_data_in.fac_11 = DG'(side_i_out.l11);
         rsp_data_in.fac_20 = side_i_out.l20;
         rsp_data_in.fac_21 = side_i_out.l21;
         rsp_data_in.fac_22 = DG'(l22_i);
         rsp_data_in.status = side_i_out.sat ? chol_pkg::STATUS_SAT : chol_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vi;
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_npd_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == chol_pkg::STATUS_NPD) |->
         (rsp_data.fac_00 == '0) && (rsp_data.fac_10 == '0) && (rsp_data.fac_11 == '0) &&
         (rsp_data.fac_20 == '0) && (rsp_data.fac_21 == '0) && (rsp_data.fac_22 == '0))
      else $error("factor not cleared for a non positive definite word");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == chol_pkg::STATUS_OK) ||
                    (rsp_data.status == chol_pkg::STATUS_NPD) ||
                    (rsp_data.status == chol_pkg::STATUS_SAT))
      else $error("undefined status code");

   a_diag_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != chol_pkg::STATUS_NPD) |->
         (rsp_data.fac_00 != '0) && (rsp_data.fac_11 != '0) && (rsp_data.fac_22 != '0))
      else $error("zero pivot in a positive definite result");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vi) && $stable(vh_ff) && $stable(vc_ff))
      else $error("pipeline moved during a stall");

endmodule
